/* hdl/ers_pkg.sv */
// Shared types, codes and sizes for the envelope release scheduler.
// No dependencies; imported by every module of the block.
package ers_pkg;

	// Field widths fixed by the message formats
	localparam int TRK_W    = 4;
	localparam int SMP_W    = 16;
	localparam int BYTE_W   = 8;
	localparam int GAIN_W   = 16;
	localparam int MSEC_W   = 16;
	localparam int MS_W     = MSEC_W + 1;          // sustain plus attack
	localparam int TPM_W    = 8;
	localparam int PROD_W   = MS_W + TPM_W;        // deadline offset in ticks
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Defaults for the top-level parameters
	localparam int DEF_TRACKS     = 16;
	localparam int DEF_TIME_WIDTH = 32;

	// Command queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	// Register reset values
	localparam logic [TPM_W-1:0]         TPM_RESET   = 8'd10;
	localparam logic signed [GAIN_W-1:0] RGAIN_RESET = -16'sd70;

	// Codes
	localparam logic       CMD_TRIGGER = 1'b0;
	localparam logic       CMD_TICK    = 1'b1;
	localparam logic       MSG_PLAY    = 1'b0;
	localparam logic       MSG_FADE    = 1'b1;
	localparam logic [1:0] MODE_ATTACK_RELEASE = 2'd0;
	localparam logic [1:0] MODE_RELEASE        = 2'd1;
	localparam logic [1:0] MODE_ATTACK         = 2'd2;
	localparam logic [1:0] MODE_NONE           = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_MS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_GAIN = 2'd1;

	// Input transaction
	typedef struct packed {
		logic                     cmd;
		logic [TRK_W-1:0]         track;
		logic [SMP_W-1:0]         sample_number;
		logic [BYTE_W-1:0]        output_route;
		logic [BYTE_W-1:0]        play_command;
		logic [1:0]               envelope_mode;
		logic signed [GAIN_W-1:0] main_gain;
		logic [MSEC_W-1:0]        attack_ms;
		logic [MSEC_W-1:0]        sustain_ms;
		logic [MSEC_W-1:0]        release_ms;
	} item_t;

	// Output transaction
	typedef struct packed {
		logic                     kind;
		logic [TRK_W-1:0]         track_index;
		logic [SMP_W-1:0]         sample_out;
		logic [BYTE_W-1:0]        route_out;
		logic [BYTE_W-1:0]        command_out;
		logic signed [GAIN_W-1:0] fade_gain;
		logic [MSEC_W-1:0]        fade_time;
		logic                     stop_after;
		logic                     last;
	} msg_t;

	// Classified operation handed from front to back
	typedef struct packed {
		logic                     is_tick;
		logic                     arm;
		logic                     attack_en;
		logic [TRK_W-1:0]         track;
		logic [SMP_W-1:0]         sample;
		logic [BYTE_W-1:0]        route;
		logic [BYTE_W-1:0]        command;
		logic signed [GAIN_W-1:0] main_gain;
		logic [MSEC_W-1:0]        attack_ms;
		logic [MS_W-1:0]          ms;
		logic [MSEC_W-1:0]        release_ms;
	} op_t;

	// Back-end sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ARM,
		ST_PLAY,
		ST_ATTACK,
		ST_SCAN,
		ST_RELEASE
	} state_t;

endpackage

/* hdl/ers_front.sv */
// Front end: accepts input transactions, classifies them and queues them.
// Depends on ers_pkg.
module ers_front import ers_pkg::*; #(
	parameter int TRACKS = DEF_TRACKS
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_stall,
	input  item_t item,
	output logic  op_valid,
	input  logic  op_pop,
	output op_t   op_head
);

	op_t               mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              do_pop;
	logic              in_range;
	op_t               op_new;

	// Classify the incoming transaction
	always_comb begin
		in_range          = {1'b0, item.track} < (TRK_W + 1)'(TRACKS);
		op_new.is_tick    = (item.cmd == CMD_TICK);
		op_new.arm        = (item.envelope_mode == MODE_ATTACK_RELEASE ||
		                     item.envelope_mode == MODE_RELEASE) && in_range;
		op_new.attack_en  = (item.envelope_mode == MODE_ATTACK_RELEASE ||
		                     item.envelope_mode == MODE_ATTACK);
		op_new.track      = item.track;
		op_new.sample     = item.sample_number;
		op_new.route      = item.output_route;
		op_new.command    = item.play_command;
		op_new.main_gain  = item.main_gain;
		op_new.attack_ms  = item.attack_ms;
		op_new.ms         = MS_W'(item.sustain_ms) +
		                    ((item.envelope_mode == MODE_ATTACK_RELEASE) ?
		                     MS_W'(item.attack_ms) : MS_W'(0));
		op_new.release_ms = item.release_ms;
	end

	assign item_stall = (cnt_q == QCNT_W'(QDEPTH));
	assign push       = item_valid && !item_stall;
	assign op_valid   = (cnt_q != '0);
	assign do_pop     = op_pop && op_valid;
	assign op_head    = mem_q[rd_ptr_q];

	// Store queued operations
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= op_new;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(do_pop);
		end
	end

	// Fill count never exceeds depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("queue count beyond depth");

endmodule

/* hdl/ers_back.sv */
// Back end: runs queued operations, holds time, arming state and config,
// and drives the output register. Depends on ers_pkg.
module ers_back import ers_pkg::*; #(
	parameter int TRACKS     = DEF_TRACKS,
	parameter int TIME_WIDTH = DEF_TIME_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  op_valid,
	output logic                  op_pop,
	input  op_t                   op_head,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  msg_valid,
	input  logic                  msg_stall,
	output msg_t                  msg
);

	localparam int TIDX_W = (TRACKS > 1) ? $clog2(TRACKS) : 1;
	localparam int SUM_W  = (TIME_WIDTH > PROD_W) ? TIME_WIDTH : PROD_W;

	state_t                   state_q, state_d;
	op_t                      op_q;
	logic [PROD_W-1:0]        prod_s1;
	logic [TIME_WIDTH-1:0]    time_q;
	logic [TRACKS-1:0]        armed_q;
	logic [TRACKS-1:0]        exp_q;
	logic [TIDX_W-1:0]        idx_q;
	logic [TPM_W-1:0]         tpm_q;
	logic signed [GAIN_W-1:0] rgain_q;
	logic [TIME_WIDTH-1:0]    deadline_q [TRACKS];
	logic [SMP_W-1:0]         held_sample_q [TRACKS];
	logic [MSEC_W-1:0]        held_rel_q [TRACKS];
	logic                     msg_valid_q;
	msg_t                     msg_q, msg_d;
	logic                     msg_ld;
	logic                     out_free;
	logic                     tick_adv;
	logic                     arm_we;
	logic                     scan_hit;
	logic                     scan_end;
	logic                     rel_done;
	logic [TRACKS-1:0]        sel_oh;
	logic [TIDX_W-1:0]        sel_idx;
	logic [SUM_W-1:0]         dl_sum;
	logic [TIDX_W-1:0]        arm_idx;

	assign out_free = !msg_valid_q || !msg_stall;
	assign arm_idx  = op_q.track[TIDX_W-1:0];
	assign dl_sum   = SUM_W'(time_q) + SUM_W'(prod_s1);
	assign scan_hit = armed_q[idx_q] && (deadline_q[idx_q] <= time_q);
	assign scan_end = (idx_q == TIDX_W'(TRACKS - 1));

	// Pick the lowest expired track
	always_comb begin
		sel_idx = '0;
		for (int i = TRACKS - 1; i >= 0; i--) begin
			if (exp_q[i]) begin
				sel_idx = TIDX_W'(i);
			end
		end
		sel_oh = TRACKS'(1) << sel_idx;
	end

	// Sequencer: next state and message selection
	always_comb begin
		state_d  = state_q;
		op_pop   = 1'b0;
		tick_adv = 1'b0;
		arm_we   = 1'b0;
		msg_ld   = 1'b0;
		rel_done = 1'b0;
		msg_d    = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (op_valid) begin
					op_pop   = 1'b1;
					tick_adv = op_head.is_tick;
					state_d  = op_head.is_tick ? ST_SCAN : ST_ARM;
				end
			end
			ST_ARM: begin
				arm_we  = op_q.arm;
				state_d = ST_PLAY;
			end
			ST_PLAY: begin
				if (out_free) begin
					msg_ld            = 1'b1;
					msg_d.kind        = MSG_PLAY;
					msg_d.track_index = op_q.track;
					msg_d.sample_out  = op_q.sample;
					msg_d.route_out   = op_q.route;
					msg_d.command_out = op_q.command;
					msg_d.last        = !op_q.attack_en;
					state_d           = op_q.attack_en ? ST_ATTACK : ST_IDLE;
				end
			end
			ST_ATTACK: begin
				if (out_free) begin
					msg_ld            = 1'b1;
					msg_d.kind        = MSG_FADE;
					msg_d.track_index = op_q.track;
					msg_d.sample_out  = op_q.sample;
					msg_d.fade_gain   = op_q.main_gain;
					msg_d.fade_time   = op_q.attack_ms;
					msg_d.last        = 1'b1;
					state_d           = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_d = ((exp_q != '0) || scan_hit) ? ST_RELEASE : ST_IDLE;
				end
			end
			ST_RELEASE: begin
				if (out_free) begin
					msg_ld            = 1'b1;
					rel_done          = 1'b1;
					msg_d.kind        = MSG_FADE;
					msg_d.track_index = TRK_W'(sel_idx);
					msg_d.sample_out  = held_sample_q[sel_idx];
					msg_d.fade_gain   = rgain_q;
					msg_d.fade_time   = held_rel_q[sel_idx];
					msg_d.stop_after  = 1'b1;
					msg_d.last        = ((exp_q & ~sel_oh) == '0);
					if (msg_d.last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Latch the popped operation and its deadline offset
	always_ff @(posedge clk) begin
		if (op_pop) begin
			op_q    <= op_head;
			prod_s1 <= PROD_W'(op_head.ms) * PROD_W'(tpm_q);
		end
	end

	// Write per-track deadline and held values on arming
	always_ff @(posedge clk) begin
		if (arm_we) begin
			deadline_q[arm_idx]    <= dl_sum[TIME_WIDTH-1:0];
			held_sample_q[arm_idx] <= op_q.sample;
			held_rel_q[arm_idx]    <= op_q.release_ms;
		end
	end

	// Advance time, arm, scan and disarm
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q  <= '0;
			armed_q <= '0;
			exp_q   <= '0;
			idx_q   <= '0;
		end else begin
			if (tick_adv) begin
				time_q <= time_q + 1'b1;
				exp_q  <= '0;
				idx_q  <= '0;
			end
			if (arm_we) begin
				armed_q[arm_idx] <= 1'b1;
			end
			if (state_q == ST_SCAN) begin
				if (scan_hit) begin
					exp_q[idx_q]   <= 1'b1;
					armed_q[idx_q] <= 1'b0;
				end
				if (!scan_end) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (rel_done) begin
				exp_q <= exp_q & ~sel_oh;
			end
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpm_q   <= TPM_RESET;
			rgain_q <= RGAIN_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_TICKS_PER_MS) begin
				tpm_q <= cfg_data[TPM_W-1:0];
			end
			if (cfg_index == CFG_RELEASE_GAIN) begin
				rgain_q <= cfg_data[GAIN_W-1:0];
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_valid_q <= 1'b0;
		end else if (msg_ld) begin
			msg_valid_q <= 1'b1;
		end else if (!msg_stall) begin
			msg_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (msg_ld) begin
			msg_q <= msg_d;
		end
	end

	assign msg_valid = msg_valid_q;
	assign msg       = msg_q;

	// A released track is disarmed right after its scan slot
	a_disarm: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && scan_hit) |=> !armed_q[$past(idx_q)])
		else $error("expired track still armed");

	// Release phase always has a pending expired track
	a_rel_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RELEASE |-> exp_q != '0)
		else $error("release phase with nothing expired");

	// Time moves only on a popped tick
	a_time_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |=> $stable(time_q))
		else $error("time changed outside tick pop");

endmodule

/* hdl/envelope_release_scheduler.sv */
// Envelope release scheduler for a sample player: top level.
// Input channel item_valid/item_stall/item carries trigger and tick
// transactions; output channel msg_valid/msg_stall/msg carries play and
// fade messages, the final one of each input flagged by last.
// A front end classifies inputs into a two-entry queue; a back end
// sequencer runs them and feeds a single output register.
// A trigger yields a play message and, if its mode has an attack, a fade
// message (1 or 2 messages). A tick runs the deadline scan over all
// TRACKS entries with a single comparator, then one release message per
// expired track; with nothing expired it yields no message.
// A trigger passes from the queue through the sequencer's ARM and PLAY
// states; its first message is then loaded into the output register.
// Reset clears time, arming, the queue and the output register, and loads
// ticks_per_ms = 10 and release_gain = -70. When msg_stall is high the
// output register holds its transaction and the sequencer waits before
// loading another message; the queue keeps accepting until full, then item_stall rises.
// Configuration writes (cfg_we, cfg_index, cfg_data) are registered in the back end.
// Depends on ers_pkg, ers_front, ers_back.
module envelope_release_scheduler import ers_pkg::*; #(
	parameter int TRACKS     = DEF_TRACKS,
	parameter int TIME_WIDTH = DEF_TIME_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  item_t                 item,
	output logic                  msg_valid,
	input  logic                  msg_stall,
	output msg_t                  msg,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic op_valid;
	logic op_pop;
	op_t  op_head;

	ers_front #(
		.TRACKS(TRACKS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item      (item),
		.op_valid  (op_valid),
		.op_pop    (op_pop),
		.op_head   (op_head)
	);

	ers_back #(
		.TRACKS    (TRACKS),
		.TIME_WIDTH(TIME_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op_pop   (op_pop),
		.op_head  (op_head),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.msg_valid(msg_valid),
		.msg_stall(msg_stall),
		.msg      (msg)
	);

endmodule
